// ===== rtl/core/mid_pkg.sv =====
`default_nettype none

package mid_pkg;

    // Field and lattice geometry
    localparam int AXES       = 3;
    localparam int COORD_BITS = 21;
    localparam int LAT_BITS   = 21;
    localparam int CFG_BITS   = AXES * LAT_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;

    // Internal arithmetic widths
    localparam int PROD_BITS  = 2 * LAT_BITS;
    localparam int COF_BITS   = PROD_BITS + 1;
    localparam int NPROD_BITS = COF_BITS + DIFF_BITS;
    localparam int DPROD_BITS = COF_BITS + LAT_BITS;
    localparam int NUM_BITS   = NPROD_BITS + 1;
    localparam int DEN_BITS   = NUM_BITS - 1;
    localparam int QUO_BITS   = 64;
    localparam int HALF_BITS  = QUO_BITS / 2;
    localparam int PART_BITS  = HALF_BITS + 1 + LAT_BITS;
    localparam int SUM_BITS   = 2 * HALF_BITS + 2;
    localparam int ROOT_BITS  = COORD_BITS;
    localparam int RAD_BITS   = 2 * ROOT_BITS;

    localparam logic [1:0] DIMS_FULL = 2'd3;

    // Register indexes
    typedef enum logic [1:0] {
        REG_VEC_A = 2'd0,
        REG_VEC_B = 2'd1,
        REG_VEC_C = 2'd2,
        REG_DIMS  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] vec_a;
        logic [CFG_BITS-1:0] vec_b;
        logic [CFG_BITS-1:0] vec_c;
        logic [1:0]          dims;
    } lattice_cfg_t;

    // One lane of the rounding divider: scaled numerator, doubled divisor, sign
    typedef struct packed {
        logic [NUM_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
        logic                qneg;
    } div_lane_t;

    typedef struct packed {
        logic [AXES-1:0][DIFF_BITS-1:0] diff;
        logic                           singular;
        logic                           last;
    } mid_side_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_BITS-1:0] disp;
        logic                            singular;
        logic                            last;
        logic                            sat;
    } root_side_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]           length;
        logic [AXES-1:0][COORD_BITS-1:0] disp;
        logic                            singular;
        logic                            last;
    } out_item_t;

    // Pick one signed lattice component: vector k, axis i
    function automatic logic signed [LAT_BITS-1:0] lat_elem(lattice_cfg_t c, int k, int i);
        logic [CFG_BITS-1:0] v;
        case (k)
            0:       v = c.vec_a;
            1:       v = c.vec_b;
            default: v = c.vec_c;
        endcase
        return v[LAT_BITS*i +: LAT_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mid_front.sv =====
`default_nettype none

module mid_front (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                en,
    input  logic                                                in_valid,
    input  logic [mid_pkg::AXES-1:0][mid_pkg::COORD_BITS-1:0]   in_first,
    input  logic [mid_pkg::AXES-1:0][mid_pkg::COORD_BITS-1:0]   in_second,
    input  logic                                                in_last,
    input  mid_pkg::lattice_cfg_t                               cfg,
    output logic                                                out_valid,
    output mid_pkg::div_lane_t [mid_pkg::AXES-1:0]              out_lane,
    output mid_pkg::mid_side_t                                  out_side
);
    import mid_pkg::*;

    logic signed [LAT_BITS-1:0] lat [AXES][AXES];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;

    logic signed [DIFF_BITS-1:0]  s1_diff_next [AXES];
    logic signed [DIFF_BITS-1:0]  s1_diff_reg  [AXES];
    logic signed [DIFF_BITS-1:0]  s2_diff_reg  [AXES];
    logic signed [DIFF_BITS-1:0]  s3_diff_reg  [AXES];
    logic signed [DIFF_BITS-1:0]  s4_diff_reg  [AXES];
    logic signed [PROD_BITS-1:0]  s1_pa_next [AXES][AXES];
    logic signed [PROD_BITS-1:0]  s1_pb_next [AXES][AXES];
    logic signed [PROD_BITS-1:0]  s1_pa_reg  [AXES][AXES];
    logic signed [PROD_BITS-1:0]  s1_pb_reg  [AXES][AXES];
    logic signed [COF_BITS-1:0]   s2_cof_reg [AXES][AXES];
    logic signed [NPROD_BITS-1:0] s3_np_reg  [AXES][AXES];
    logic signed [DPROD_BITS-1:0] s3_dp_reg  [AXES];
    logic signed [NUM_BITS-1:0]   s4_num_reg [AXES];
    logic signed [NUM_BITS-1:0]   s4_det_reg;

    div_lane_t [AXES-1:0] s5_lane_next;
    div_lane_t [AXES-1:0] s5_lane_reg;
    mid_side_t            s5_side_next;
    mid_side_t            s5_side_reg;

    // Decode lattice components from the configuration
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                lat[k][i] = lat_elem(cfg, k, i);
            end
        end
    end

    // Stage 1: differences and cofactor partial products
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            s1_diff_next[i] = $signed({in_second[i][COORD_BITS-1], in_second[i]})
                            - $signed({in_first[i][COORD_BITS-1], in_first[i]});
        end
        for (int k = 0; k < AXES; k++)
        begin
            for (int j = 0; j < AXES; j++)
            begin
                s1_pa_next[k][j] = lat[(k+1)%AXES][(j+1)%AXES] * lat[(k+2)%AXES][(j+2)%AXES];
                s1_pb_next[k][j] = lat[(k+1)%AXES][(j+2)%AXES] * lat[(k+2)%AXES][(j+1)%AXES];
            end
        end
    end

    // Stage 5: pick operands for the divider and fold in rounding
    always_comb
    begin
        logic                       diag;
        logic signed [NUM_BITS-1:0] num;
        logic signed [NUM_BITS-1:0] den;
        logic [NUM_BITS-1:0]        mnum;
        logic [NUM_BITS-1:0]        mden;
        logic                       any_zero;
        diag     = (cfg.dims != DIMS_FULL);
        any_zero = 1'b0;
        for (int k = 0; k < AXES; k++)
        begin
            if (diag)
            begin
                num = NUM_BITS'(s4_diff_reg[k]);
                den = NUM_BITS'(lat[k][k]);
            end
            else
            begin
                num = s4_num_reg[k];
                den = s4_det_reg;
            end
            mnum = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
            mden = den[NUM_BITS-1] ? NUM_BITS'(-den) : NUM_BITS'(den);
            if (den == '0)
            begin
                // zero divisor: quotient must come out zero
                any_zero             = 1'b1;
                s5_lane_next[k].num  = '0;
                s5_lane_next[k].den  = '1;
            end
            else
            begin
                s5_lane_next[k].num  = {mnum[NUM_BITS-2:0], 1'b0} + mden;
                s5_lane_next[k].den  = {mden[DEN_BITS-2:0], 1'b0};
            end
            s5_lane_next[k].qneg = num[NUM_BITS-1] ^ den[NUM_BITS-1];
            s5_side_next.diff[k] = s4_diff_reg[k];
        end
        s5_side_next.singular = any_zero;
        s5_side_next.last     = s4_last_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_last_reg <= in_last;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
            for (int i = 0; i < AXES; i++)
            begin
                s1_diff_reg[i] <= s1_diff_next[i];
                s2_diff_reg[i] <= s1_diff_reg[i];
                s3_diff_reg[i] <= s2_diff_reg[i];
                s4_diff_reg[i] <= s3_diff_reg[i];
                s3_dp_reg[i]   <= lat[0][i] * s2_cof_reg[0][i];
            end
            for (int k = 0; k < AXES; k++)
            begin
                for (int j = 0; j < AXES; j++)
                begin
                    s1_pa_reg[k][j]  <= s1_pa_next[k][j];
                    s1_pb_reg[k][j]  <= s1_pb_next[k][j];
                    s2_cof_reg[k][j] <= COF_BITS'(s1_pa_reg[k][j]) - COF_BITS'(s1_pb_reg[k][j]);
                    s3_np_reg[k][j]  <= s2_cof_reg[k][j] * s2_diff_reg[j];
                end
                s4_num_reg[k] <= NUM_BITS'(s3_np_reg[k][0]) + NUM_BITS'(s3_np_reg[k][1])
                               + NUM_BITS'(s3_np_reg[k][2]);
            end
            s4_det_reg  <= NUM_BITS'(s3_dp_reg[0]) + NUM_BITS'(s3_dp_reg[1])
                         + NUM_BITS'(s3_dp_reg[2]);
            s5_lane_reg <= s5_lane_next;
            s5_side_reg <= s5_side_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_lane  = s5_lane_reg;
    assign out_side  = s5_side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mid_div.sv =====
`default_nettype none

module mid_div (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              en,
    input  logic                                              in_valid,
    input  mid_pkg::div_lane_t [mid_pkg::AXES-1:0]            in_lane,
    input  mid_pkg::mid_side_t                                in_side,
    output logic                                              out_valid,
    output logic [mid_pkg::AXES-1:0][mid_pkg::QUO_BITS-1:0]   out_quo,
    output mid_pkg::mid_side_t                                out_side
);
    import mid_pkg::*;

    localparam int STEPS = NUM_BITS;

    logic                v_prev    [STEPS];
    mid_side_t           side_prev [STEPS];
    div_lane_t           lane_prev [STEPS][AXES];
    logic [DEN_BITS-1:0] rem_prev  [STEPS][AXES];
    logic [QUO_BITS-1:0] q_prev    [STEPS][AXES];

    logic                v_reg    [STEPS];
    mid_side_t           side_reg [STEPS];
    div_lane_t           lane_reg [STEPS][AXES];
    logic [DEN_BITS-1:0] rem_reg  [STEPS][AXES];
    logic [QUO_BITS-1:0] q_reg    [STEPS][AXES];

    logic                            out_valid_reg;
    logic [AXES-1:0][QUO_BITS-1:0]   out_quo_reg;
    mid_side_t                       out_side_reg;

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        if (j == 0)
        begin : g_head
            assign v_prev[j]    = in_valid;
            assign side_prev[j] = in_side;
            for (genvar k = 0; k < AXES; k++)
            begin : g_lane
                assign lane_prev[j][k] = in_lane[k];
                assign rem_prev[j][k]  = '0;
                assign q_prev[j][k]    = '0;
            end
        end
        else
        begin : g_link
            assign v_prev[j]    = v_reg[j-1];
            assign side_prev[j] = side_reg[j-1];
            for (genvar k = 0; k < AXES; k++)
            begin : g_lane
                assign lane_prev[j][k] = lane_reg[j-1][k];
                assign rem_prev[j][k]  = rem_reg[j-1][k];
                assign q_prev[j][k]    = q_reg[j-1][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_prev[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_prev[j];
            end
        end

        for (genvar k = 0; k < AXES; k++)
        begin : g_sub
            logic [NUM_BITS-1:0] trial;
            logic [NUM_BITS-1:0] sub;
            logic                ge;

            // Shift in the next numerator bit and try the subtract
            assign trial = {rem_prev[j][k], lane_prev[j][k].num[STEPS-1-j]};
            assign ge    = (trial >= {1'b0, lane_prev[j][k].den});
            assign sub   = trial - {1'b0, lane_prev[j][k].den};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lane_reg[j][k] <= lane_prev[j][k];
                    rem_reg[j][k]  <= ge ? sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                    q_reg[j][k]    <= {q_prev[j][k][QUO_BITS-2:0], ge};
                end
            end
        end
    end

    // Apply the quotient sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                out_quo_reg[k] <= lane_reg[STEPS-1][k].qneg ? (~q_reg[STEPS-1][k] + 1'b1)
                                                             : q_reg[STEPS-1][k];
            end
            out_side_reg <= side_reg[STEPS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_quo   = out_quo_reg;
    assign out_side  = out_side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mid_back.sv =====
`default_nettype none

module mid_back (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              en,
    input  logic                                              in_valid,
    input  logic [mid_pkg::AXES-1:0][mid_pkg::QUO_BITS-1:0]   in_quo,
    input  mid_pkg::mid_side_t                                in_side,
    input  mid_pkg::lattice_cfg_t                             cfg,
    output logic                                              out_valid,
    output logic [mid_pkg::RAD_BITS-1:0]                      out_rad,
    output mid_pkg::root_side_t                               out_side
);
    import mid_pkg::*;

    logic signed [LAT_BITS-1:0] op [AXES][AXES];

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg, b5_valid_reg, b6_valid_reg;
    mid_side_t  b1_side_reg, b2_side_reg;
    root_side_t b4_side_next, b4_side_reg, b5_side_reg, b6_side_reg;

    logic signed [PART_BITS-1:0] b1_lo_next [AXES][AXES];
    logic signed [PART_BITS-1:0] b1_hi_next [AXES][AXES];
    logic signed [PART_BITS-1:0] b1_lo_reg  [AXES][AXES];
    logic [HALF_BITS-1:0]        b1_hi_reg  [AXES][AXES];
    logic [QUO_BITS-1:0]         b2_term_reg [AXES][AXES];
    logic [QUO_BITS-1:0]         b3_acc_reg [AXES];
    logic                        b3_singular_reg, b3_last_reg;
    logic [HALF_BITS-1:0]        b4_mag_next [AXES];
    logic [HALF_BITS-1:0]        b4_mag_reg  [AXES];
    logic [QUO_BITS-1:0]         b5_sq_reg [AXES];
    logic [SUM_BITS-1:0]         b6_sum_next;
    logic [RAD_BITS-1:0]         b6_rad_reg;

    // Stage 1: lattice operands masked by mode, split 64 by 21 products
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                op[k][i] = ((cfg.dims == DIMS_FULL) || (k == i)) ? lat_elem(cfg, k, i) : '0;
                b1_lo_next[k][i] = $signed({1'b0, in_quo[k][HALF_BITS-1:0]}) * op[k][i];
                b1_hi_next[k][i] = $signed({1'b0, in_quo[k][QUO_BITS-1:HALF_BITS]}) * op[k][i];
            end
        end
    end

    // Stage 4: magnitude, overflow flag and clamp
    always_comb
    begin
        logic [QUO_BITS-1:0] a;
        logic                fits;
        logic                huge;
        huge = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            a    = b3_acc_reg[i];
            fits = (&a[QUO_BITS-1:COORD_BITS-1]) || (~|a[QUO_BITS-1:COORD_BITS-1]);
            if (fits)
            begin
                b4_side_next.disp[i] = a[COORD_BITS-1:0];
            end
            else if (a[QUO_BITS-1])
            begin
                b4_side_next.disp[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            end
            else
            begin
                b4_side_next.disp[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
            end
            a = a[QUO_BITS-1] ? (~a + 1'b1) : a;
            huge = huge | (|a[QUO_BITS-1:HALF_BITS]);
            b4_mag_next[i] = a[HALF_BITS-1:0];
        end
        b4_side_next.singular = b3_singular_reg;
        b4_side_next.last     = b3_last_reg;
        b4_side_next.sat      = huge;
    end

    assign b6_sum_next = SUM_BITS'(b5_sq_reg[0]) + SUM_BITS'(b5_sq_reg[1])
                       + SUM_BITS'(b5_sq_reg[2]);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
            b6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
            b6_valid_reg <= b5_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_side_reg <= in_side;
            b2_side_reg <= b1_side_reg;
            for (int k = 0; k < AXES; k++)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    b1_lo_reg[k][i]   <= b1_lo_next[k][i];
                    b1_hi_reg[k][i]   <= b1_hi_next[k][i][HALF_BITS-1:0];
                    b2_term_reg[k][i] <= QUO_BITS'(b1_lo_reg[k][i])
                                       + {b1_hi_reg[k][i], {HALF_BITS{1'b0}}};
                end
            end
            for (int i = 0; i < AXES; i++)
            begin
                b3_acc_reg[i] <= QUO_BITS'($signed(b2_side_reg.diff[i]))
                               - b2_term_reg[0][i] - b2_term_reg[1][i] - b2_term_reg[2][i];
                b4_mag_reg[i] <= b4_mag_next[i];
                b5_sq_reg[i]  <= b4_mag_reg[i] * b4_mag_reg[i];
            end
            b3_singular_reg <= b2_side_reg.singular;
            b3_last_reg     <= b2_side_reg.last;
            b4_side_reg     <= b4_side_next;
            b5_side_reg     <= b4_side_reg;
            b6_rad_reg      <= b6_sum_next[RAD_BITS-1:0];
            b6_side_reg.disp     <= b5_side_reg.disp;
            b6_side_reg.singular <= b5_side_reg.singular;
            b6_side_reg.last     <= b5_side_reg.last;
            // saturate when the square sum reaches past the root range
            b6_side_reg.sat <= b5_side_reg.sat | (|b6_sum_next[SUM_BITS-1:RAD_BITS]);
        end
    end

    assign out_valid = b6_valid_reg;
    assign out_rad   = b6_rad_reg;
    assign out_side  = b6_side_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mid_sqrt.sv =====
`default_nettype none

module mid_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mid_pkg::RAD_BITS-1:0]  in_rad,
    input  mid_pkg::root_side_t           in_side,
    output logic                          out_valid,
    output mid_pkg::out_item_t            out_item
);
    import mid_pkg::*;

    localparam int STEPS   = ROOT_BITS;
    localparam int TRY_BITS = RAD_BITS + 2;

    logic                 v_prev    [STEPS];
    root_side_t           side_prev [STEPS];
    logic [RAD_BITS-1:0]  rem_prev  [STEPS];
    logic [ROOT_BITS-1:0] root_prev [STEPS];

    logic                 v_reg    [STEPS];
    root_side_t           side_reg [STEPS];
    logic [RAD_BITS-1:0]  rem_reg  [STEPS];
    logic [ROOT_BITS-1:0] root_reg [STEPS];

    logic                 out_valid_reg;
    out_item_t            out_item_reg;
    out_item_t            out_item_next;

    // One root bit per stage, most significant first
    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic [TRY_BITS-1:0] trial;
        logic [TRY_BITS-1:0] rem_ext;
        logic [TRY_BITS-1:0] sub;
        logic                ge;

        if (j == 0)
        begin : g_head
            assign v_prev[j]    = in_valid;
            assign side_prev[j] = in_side;
            assign rem_prev[j]  = in_rad;
            assign root_prev[j] = '0;
        end
        else
        begin : g_link
            assign v_prev[j]    = v_reg[j-1];
            assign side_prev[j] = side_reg[j-1];
            assign rem_prev[j]  = rem_reg[j-1];
            assign root_prev[j] = root_reg[j-1];
        end

        // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
        assign trial   = (TRY_BITS'(root_prev[j]) << (STEPS - j))
                       + (TRY_BITS'(1) << (2 * (STEPS - 1 - j)));
        assign rem_ext = TRY_BITS'(rem_prev[j]);
        assign ge      = (rem_ext >= trial);
        assign sub     = rem_ext - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_prev[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_prev[j];
                rem_reg[j]  <= ge ? sub[RAD_BITS-1:0] : rem_prev[j];
                root_reg[j] <= ge ? (root_prev[j] | (ROOT_BITS'(1) << (STEPS - 1 - j)))
                                  : root_prev[j];
            end
        end
    end

    // Round half up and clamp to the field maximum
    always_comb
    begin
        logic [ROOT_BITS:0] rounded;
        rounded = {1'b0, root_reg[STEPS-1]}
                + (ROOT_BITS+1)'(rem_reg[STEPS-1] > RAD_BITS'(root_reg[STEPS-1]));
        if (side_reg[STEPS-1].sat || rounded[ROOT_BITS])
        begin
            out_item_next.length = '1;
        end
        else
        begin
            out_item_next.length = rounded[ROOT_BITS-1:0];
        end
        out_item_next.disp     = side_reg[STEPS-1].disp;
        out_item_next.singular = side_reg[STEPS-1].singular;
        out_item_next.last     = side_reg[STEPS-1].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/minimum_image_displacement.sv =====
// Channel | Direction | Handshake          | Payload
// s_*     | in        | s_tvalid/s_tready  | s_tdata position pair, s_tlast end of set
// m_*     | out       | m_tvalid/m_tready  | m_tdata displacement and length,
//         |           |                    | m_tuser singular, m_tlast end of set
// cfg_*   | in        | cfg_we             | cfg_index register, cfg_data value
//
// One item per cycle sustained while the skid stage is empty; an item passes 101 register
// stages, among them the 66-stage rounding divider and the 21-stage square root.
// Reset clears all valid bits and loads the reset lattice; no clearing pass.
// A stalled result goes to a skid stage; s_tready falls only when it is full,
// and then the whole pipeline holds without losing or repeating an item.
`default_nettype none

module minimum_image_displacement (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, 2 pad bits
    input  logic [127:0]                  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // disp_x, disp_y, disp_z, distance, 4 pad bits
    output logic [87:0]                   m_tdata,
    // singular
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [mid_pkg::CFG_BITS-1:0]  cfg_data
);
    import mid_pkg::*;

    lattice_cfg_t cfg_reg;

    logic en;
    logic push, pop;
    logic out_valid_reg, skid_valid_reg;
    out_item_t out_item_reg, skid_item_reg;

    logic                 fr_valid;
    div_lane_t [AXES-1:0] fr_lane;
    mid_side_t            fr_side;
    logic                 dv_valid;
    logic [AXES-1:0][QUO_BITS-1:0] dv_quo;
    mid_side_t            dv_side;
    logic                 bk_valid;
    logic [RAD_BITS-1:0]  bk_rad;
    root_side_t           bk_side;
    logic                 sq_valid;
    out_item_t            sq_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vec_a <= '0;
            cfg_reg.vec_b <= '0;
            cfg_reg.vec_c <= '0;
            cfg_reg.dims  <= DIMS_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VEC_A: cfg_reg.vec_a <= cfg_data;
                REG_VEC_B: cfg_reg.vec_b <= cfg_data;
                REG_VEC_C: cfg_reg.vec_c <= cfg_data;
                REG_DIMS:  cfg_reg.dims  <= cfg_data[1:0];
            endcase
        end
    end

    // Pipeline advances unless the skid stage is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    mid_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_first  (s_tdata[AXES*COORD_BITS-1:0]),
        .in_second (s_tdata[2*AXES*COORD_BITS-1:AXES*COORD_BITS]),
        .in_last   (s_tlast),
        .cfg       (cfg_reg),
        .out_valid (fr_valid),
        .out_lane  (fr_lane),
        .out_side  (fr_side)
    );

    mid_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_lane   (fr_lane),
        .in_side   (fr_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    mid_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .in_quo    (dv_quo),
        .in_side   (dv_side),
        .cfg       (cfg_reg),
        .out_valid (bk_valid),
        .out_rad   (bk_rad),
        .out_side  (bk_side)
    );

    mid_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bk_valid),
        .in_rad    (bk_rad),
        .in_side   (bk_side),
        .out_valid (sq_valid),
        .out_item  (sq_item)
    );

    // Output register with skid stage
    assign push = sq_valid && en;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (push)
            begin
                out_item_reg <= sq_item;
            end
        end
        else if (push)
        begin
            skid_item_reg <= sq_item;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_item_reg.length, out_item_reg.disp};
    assign m_tuser  = out_item_reg.singular;
    assign m_tlast  = out_item_reg.last;

`ifndef SYNTHESIS
    // Skid holds an item only behind a held output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid occupied while output empty");

    // Skid fills only when the output was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without a stall");

    // Zero length only for a zero displacement
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.length == '0)) |-> (out_item_reg.disp == '0))
        else $error("zero distance with nonzero displacement");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_minimum_image_displacement.sv =====
`default_nettype none

module tb_minimum_image_displacement;
    timeunit 1ns;
    timeprecision 1ps;
    import mid_pkg::*;

    localparam int LATENCY = 101;
    localparam logic signed [20:0] CMAX = 21'sh0FFFFF;
    localparam logic signed [20:0] CMIN = -21'sh100000;

    typedef struct packed {
        logic [20:0] dx;
        logic [20:0] dy;
        logic [20:0] dz;
        logic [20:0] length;
        logic        singular;
        logic        last;
    } disp_item_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // Shadow copy of the lattice registers
    logic [62:0] lat_reg [3];
    logic [1:0]  dims_reg;

    disp_item_t  expected_disp [$];
    int          errors = 0;
    int          results_seen = 0;
    bit          idle_on = 1'b1;

    minimum_image_displacement dut (.*);

    always #10 clk = ~clk;

    // Signed lattice component: vector k, axis i
    function automatic longint lat_comp(int k, int i);
        logic signed [20:0] v;
        v = lat_reg[k][21*i +: 21];
        return longint'(v);
    endfunction

    // Round num/den half away from zero
    function automatic longint round_div(logic signed [127:0] num, longint den);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic signed [127:0] q;
        bit neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -128'(den) : 128'(den);
        q = (2 * n + d) / (2 * d);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > longint'(CMAX)) return longint'(CMAX);
        if (v < longint'(CMIN)) return longint'(CMIN);
        return v;
    endfunction

    // Integer square root rounded to nearest
    function automatic longint unsigned root_round(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (s > r) r++;
        return r;
    endfunction

    // Compute the expected displacement for one position pair
    function automatic disp_item_t predict_disp(logic [125:0] pos, logic last);
        disp_item_t o;
        longint d [3];
        longint r [3];
        longint l [3][3];
        longint cof [3][3];
        longint det;
        longint n [3];
        logic signed [127:0] acc;
        logic signed [20:0] a;
        logic signed [20:0] b;
        longint unsigned s;
        longint unsigned m;
        bit sing;
        bit huge;
        sing = 0;
        huge = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
                l[k][i] = lat_comp(k, i);
        for (int i = 0; i < 3; i++)
        begin
            a = pos[21*i +: 21];
            b = pos[21*(i+3) +: 21];
            d[i] = longint'(b) - longint'(a);
        end
        if (dims_reg < DIMS_FULL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (l[i][i] == 0)
                begin
                    r[i] = d[i];
                    sing = 1;
                end
                else
                    r[i] = d[i] - round_div(128'(d[i]), l[i][i]) * l[i][i];
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                cof[k][0] = l[(k+1)%3][1]*l[(k+2)%3][2] - l[(k+1)%3][2]*l[(k+2)%3][1];
                cof[k][1] = l[(k+1)%3][2]*l[(k+2)%3][0] - l[(k+1)%3][0]*l[(k+2)%3][2];
                cof[k][2] = l[(k+1)%3][0]*l[(k+2)%3][1] - l[(k+1)%3][1]*l[(k+2)%3][0];
            end
            det = l[0][0]*cof[0][0] + l[0][1]*cof[0][1] + l[0][2]*cof[0][2];
            if (det == 0)
            begin
                sing = 1;
                for (int i = 0; i < 3; i++) r[i] = d[i];
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    acc = 0;
                    for (int i = 0; i < 3; i++)
                        acc += 128'(cof[k][i]) * 128'(d[i]);
                    n[k] = round_div(acc, det);
                end
                for (int i = 0; i < 3; i++)
                begin
                    r[i] = d[i];
                    for (int k = 0; k < 3; k++) r[i] -= n[k] * l[k][i];
                end
            end
        end
        // Sum of squares with overflow detection
        for (int i = 0; i < 3; i++)
        begin
            m = (r[i] < 0) ? -r[i] : r[i];
            if (m > 64'hFFFF_FFFF)
                huge = 1;
            else
            begin
                if (s + m*m < s) huge = 1;
                s += m*m;
            end
        end
        m = huge ? 64'h1F_FFFF : root_round(s);
        if (m > 64'h1F_FFFF) m = 64'h1F_FFFF;
        o.dx = 21'(sat_coord(r[0]));
        o.dy = 21'(sat_coord(r[1]));
        o.dz = 21'(sat_coord(r[2]));
        o.length = 21'(m);
        o.singular = sing;
        o.last = last;
        return o;
    endfunction

    // Send one position pair and queue its expected result
    task automatic send_pair(logic [125:0] pos, logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pos};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_disp.push_back(predict_disp(pos, last));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_disp.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [62:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_DIMS) dims_reg = val[1:0];
        else lat_reg[idx] = val;
    endtask

    function automatic logic [62:0] pack_vec(int x, int y, int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    task automatic set_lattice(logic [62:0] a, logic [62:0] b, logic [62:0] c,
                               logic [1:0] dm);
        drain();
        write_reg(REG_VEC_A, a);
        write_reg(REG_VEC_B, b);
        write_reg(REG_VEC_C, c);
        write_reg(REG_DIMS, dm);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [20:0] rand_coord(int span);
        case ($urandom_range(0, 9))
            0: return CMAX;
            1: return CMIN;
            2: return 21'($urandom);
            default: return 21'($urandom_range(0, 2*span) - span);
        endcase
    endfunction

    function automatic logic [125:0] rand_pair(int span);
        logic [125:0] p;
        for (int i = 0; i < 6; i++) p[21*i +: 21] = rand_coord(span);
        return p;
    endfunction

    // Reset lattice is all zero: every pair is singular in full mode
    task automatic test_reset_lattice();
        send_pair({6{CMAX}}, 1'b0);
        send_pair({{3{CMAX}}, {3{CMIN}}}, 1'b1);
        send_pair({{3{CMIN}}, {3{CMAX}}}, 1'b0);
        send_pair('0, 1'b1);
    endtask

    // Diagonal mode with tie cases and a zero diagonal axis
    task automatic test_diagonal();
        set_lattice(pack_vec(2048, 777, -5), pack_vec(3, -4096, 9), pack_vec(1, 2, 0), 2'd1);
        send_pair({21'd0, 21'd2048, 21'd1024, 63'd0}, 1'b0);
        send_pair({21'd5, -21'sd2048, -21'sd1024, 63'd0}, 1'b1);
        send_pair({21'd0, 21'd3072, 21'd3072, 63'd0}, 1'b0);
        send_pair({6{CMIN}}, 1'b0);
        send_pair({{3{CMAX}}, {3{CMIN}}}, 1'b1);
        set_lattice(pack_vec(-1, 0, 0), pack_vec(0, 1, 0), pack_vec(0, 0, 21'h0FFFFF), 2'd0);
        send_pair({{3{CMAX}}, {3{CMIN}}}, 1'b0);
        send_pair({{3{CMIN}}, {3{CMAX}}}, 1'b1);
        set_lattice(pack_vec(CMIN, 0, 0), pack_vec(0, CMIN, 0), pack_vec(0, 0, CMIN), 2'd2);
        send_pair({{3{CMAX}}, {3{CMIN}}}, 1'b0);
        send_pair({21'd1, 21'd1, 21'd1, 63'd0}, 1'b1);
    endtask

    // General triclinic lattices, degenerate and extreme ones included
    task automatic test_general();
        set_lattice(pack_vec(10240, 0, 0), pack_vec(3000, 9000, 0),
                    pack_vec(-2000, 1500, 8000), DIMS_FULL);
        send_pair({{3{21'd5120}}, 63'd0}, 1'b0);
        send_pair({{3{CMAX}}, {3{CMIN}}}, 1'b1);
        send_pair({21'd7, -21'sd12000, 21'd40000, 63'd0}, 1'b0);
        set_lattice(pack_vec(5, 6, 7), pack_vec(10, 12, 14), pack_vec(1, 2, 3), DIMS_FULL);
        send_pair({{3{21'd100}}, {3{21'd3}}}, 1'b1);
        set_lattice({3{CMAX}}, {CMIN, CMAX, CMIN}, {CMAX, CMIN, CMIN}, DIMS_FULL);
        send_pair({{3{CMAX}}, {3{CMIN}}}, 1'b0);
        send_pair({{3{CMIN}}, {3{CMAX}}}, 1'b1);
        set_lattice(pack_vec(1, 0, 0), pack_vec(0, 1, 0), pack_vec(0, 0, 1), DIMS_FULL);
        send_pair({{3{CMIN}}, {3{CMAX}}}, 1'b1);
    endtask

    // Random lattices in all modes, random pairs
    task automatic test_random();
        logic [62:0] v [3];
        int span;
        for (int phase = 0; phase < 24; phase++)
        begin
            span = $urandom_range(0, 1) ? 4000 : 1000000;
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    v[k] = 63'({$urandom, $urandom});
                else
                    for (int i = 0; i < 3; i++)
                        v[k][21*i +: 21] = (i == k) ? 21'($urandom_range(256, 60000))
                                                    : 21'($urandom_range(0, 8000) - 4000);
            end
            if (phase >= 20) idle_on = 1'b0;
            set_lattice(v[0], v[1], v[2], 2'($urandom_range(1, 3)));
            for (int j = 0; j < 80; j++)
                send_pair(rand_pair(span), 1'($urandom));
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        disp_item_t got;
        disp_item_t exp_item;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[20:0], m_tdata[41:21], m_tdata[62:42], m_tdata[83:63],
                   m_tuser, m_tlast};
            results_seen++;
            if (expected_disp.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                exp_item = expected_disp.pop_front();
                if (got.dx !== exp_item.dx || got.dy !== exp_item.dy ||
                    got.dz !== exp_item.dz || got.length !== exp_item.length ||
                    got.singular !== exp_item.singular || got.last !== exp_item.last)
                begin
                    $display("%0t: mismatch expected dx %h dy %h dz %h dist %h sing %b last %b",
                             $time, exp_item.dx, exp_item.dy, exp_item.dz, exp_item.length,
                             exp_item.singular, exp_item.last);
                    $display("%0t:          actual dx %h dy %h dz %h dist %h sing %b last %b",
                             $time, got.dx, got.dy, got.dz, got.length, got.singular,
                             got.last);
                    errors++;
                end
            end
        end
    end

    // Receiver stall bursts
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        for (int k = 0; k < 3; k++) lat_reg[k] = '0;
        dims_reg = DIMS_FULL;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_lattice();
        test_diagonal();
        test_general();
        test_random();
        drain();
        $display("Covered %0d results over diagonal, general and degenerate lattices,",
                 results_seen);
        $display("with field extremes, rounding ties and saturation.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
